FILE: rtl/core/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg: shared types and constants of the byte-run RLE row packer
// Command format between the front and back ends, default packet limits and
// the field widths of the stream ports.
// ----------------------------------------------------------------------------
package brle_pkg;

   localparam int MAX_LITERAL_DEF = 128;
   localparam int MAX_REPEAT_DEF  = 128;
   localparam int MIN_REPEAT_DEF  = 3;

   localparam int BYTE_W      = 8;
   localparam int CNT_W       = 8;
   localparam int LANES       = 8;
   localparam int LANE_W      = 3;
   localparam int BCOUNT_W    = 4;
   localparam int OUT_W       = LANES * BYTE_W;
   localparam int RSP_TDATA_W = 72;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // Command kinds
   localparam logic CMD_PAIR = 1'b0;
   localparam logic CMD_LIT  = 1'b1;

   // PAIR sends imm0 then imm1. LIT sends imm0 (the count byte n-1) and then
   // n bytes of the literal buffer bank given by bank.
   typedef struct packed {
      logic              kind;
      logic              bank;
      logic [BYTE_W-1:0] imm0;
      logic [BYTE_W-1:0] imm1;
      logic              last;
      logic              row;
   } cmd_type;

   typedef struct packed {
      logic    a_valid;
      cmd_type a;
      logic    b_valid;
      cmd_type b;
   } push_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

endpackage

FILE: rtl/core/brle_ram.sv
// ----------------------------------------------------------------------------
// brle_ram: generic simple dual-port RAM
// One write port and one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module brle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/brle_front.sv
// ----------------------------------------------------------------------------
// brle_front: row byte classifier
// Tracks literal and run state per row, writes literal bytes into one of two
// buffer banks and issues packet commands to the command queue.
// ----------------------------------------------------------------------------
module brle_front #(
   parameter int MAX_LITERAL = brle_pkg::MAX_LITERAL_DEF,
   parameter int MAX_REPEAT  = brle_pkg::MAX_REPEAT_DEF,
   parameter int MIN_REPEAT  = brle_pkg::MIN_REPEAT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [brle_pkg::BYTE_W-1:0]         in_byte,
   input  logic                                in_end,
   input  logic                                q_room,
   input  brle_pkg::rel_type                   rel,
   output brle_pkg::push_type                  push,
   output logic                                wr_en,
   output logic [$clog2(MAX_LITERAL):0]        wr_addr,
   output logic [brle_pkg::BYTE_W-1:0]         wr_data
);

   localparam int LIT_AW = $clog2(MAX_LITERAL);
   localparam int CW     = brle_pkg::CNT_W;

   logic          open_ff, open_in;
   logic          run_ff, run_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] rs_ff, rs_in;
   logic [brle_pkg::BYTE_W-1:0] prev_ff, prev_in;
   logic          bank_ff, bank_in;
   logic [1:0]    busy_ff, busy_in;

   logic              accept;
   logic              has_lit;
   logic              wr_req;
   logic [LIT_AW:0]   wr_addr_c;
   logic [CW-1:0]     f1;
   brle_pkg::cmd_type cmd_a, cmd_b;
   logic              a_v, b_v;

   always_comb begin
      open_in   = open_ff;
      run_in    = run_ff;
      fill_in   = fill_ff;
      rs_in     = rs_ff;
      prev_in   = in_byte;
      bank_in   = bank_ff;
      f1        = fill_ff + CW'(1);
      cmd_a     = '0;
      cmd_b     = '0;
      a_v       = 1'b0;
      b_v       = 1'b0;
      has_lit   = 1'b0;
      wr_req    = 1'b0;
      wr_addr_c = {bank_ff, {LIT_AW{1'b0}}};

      if (!open_ff) begin
         wr_req  = 1'b1;
         fill_in = CW'(1);
         rs_in   = '0;
         run_in  = 1'b0;
         open_in = 1'b1;
      end else if (!run_ff) begin
         if (fill_ff >= CW'(MAX_LITERAL)) begin
            // Full buffer: flush it and open the other bank with this byte.
            a_v        = 1'b1;
            cmd_a.kind = brle_pkg::CMD_LIT;
            cmd_a.bank = bank_ff;
            cmd_a.imm0 = fill_ff - CW'(1);
            has_lit    = 1'b1;
            bank_in    = ~bank_ff;
            wr_req     = 1'b1;
            wr_addr_c  = {~bank_ff, {LIT_AW{1'b0}}};
            fill_in    = CW'(1);
            rs_in      = '0;
         end else begin
            wr_req    = 1'b1;
            wr_addr_c = {bank_ff, fill_ff[LIT_AW-1:0]};
            fill_in   = f1;
            if (in_byte == prev_ff) begin
               if (f1 - rs_ff >= CW'(MIN_REPEAT)) begin
                  if (rs_ff != '0) begin
                     a_v        = 1'b1;
                     cmd_a.kind = brle_pkg::CMD_LIT;
                     cmd_a.bank = bank_ff;
                     cmd_a.imm0 = rs_ff - CW'(1);
                     has_lit    = 1'b1;
                     bank_in    = ~bank_ff;
                  end
                  run_in  = 1'b1;
                  fill_in = f1 - rs_ff;
               end else if (rs_ff == '0) begin
                  run_in = 1'b1;
               end
            end else begin
               rs_in = fill_ff;
            end
         end
      end else begin
         // In run mode fill_ff holds the run length so far.
         if (in_byte != prev_ff || f1 > CW'(MAX_REPEAT)) begin
            a_v        = 1'b1;
            cmd_a.kind = brle_pkg::CMD_PAIR;
            cmd_a.imm0 = CW'(0) - (f1 - CW'(2));
            cmd_a.imm1 = prev_ff;
            wr_req     = 1'b1;
            fill_in    = CW'(1);
            rs_in      = '0;
            run_in     = 1'b0;
         end else begin
            fill_in = f1;
         end
      end

      if (in_end) begin
         b_v = 1'b1;
         if (!run_in) begin
            if (fill_in == CW'(1)) begin
               // A single pending byte is always the byte just taken.
               cmd_b.kind = brle_pkg::CMD_PAIR;
               cmd_b.imm0 = '0;
               cmd_b.imm1 = in_byte;
            end else begin
               cmd_b.kind = brle_pkg::CMD_LIT;
               cmd_b.bank = bank_in;
               cmd_b.imm0 = fill_in - CW'(1);
               has_lit    = 1'b1;
               bank_in    = ~bank_in;
            end
         end else begin
            cmd_b.kind = brle_pkg::CMD_PAIR;
            cmd_b.imm0 = CW'(0) - (fill_in - CW'(1));
            cmd_b.imm1 = in_byte;
         end
         cmd_b.last = 1'b1;
         cmd_b.row  = 1'b1;
         open_in    = 1'b0;
         run_in     = 1'b0;
         fill_in    = '0;
         rs_in      = '0;
      end
      cmd_a.last = ~b_v;
   end

   // A literal flush hands the current bank to the back end, so the other
   // bank must be free before the beat can be taken.
   assign in_ready = q_room && !(has_lit && busy_ff[~bank_ff]);
   assign accept   = in_valid && in_ready;

   always_comb begin
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (accept && has_lit) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   assign push.a_valid = accept && a_v;
   assign push.a       = cmd_a;
   assign push.b_valid = accept && b_v;
   assign push.b       = cmd_b;
   assign wr_en        = accept && wr_req;
   assign wr_addr      = wr_addr_c;
   assign wr_data      = in_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         run_ff  <= 1'b0;
         fill_ff <= '0;
         rs_ff   <= '0;
         prev_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         if (accept) begin
            open_ff <= open_in;
            run_ff  <= run_in;
            fill_ff <= fill_in;
            rs_ff   <= rs_in;
            prev_ff <= prev_in;
            bank_ff <= bank_in;
         end
      end
   end

endmodule

FILE: rtl/core/brle_cmdq.sv
// ----------------------------------------------------------------------------
// brle_cmdq: packet command queue
// Small register FIFO that takes up to two commands per cycle from the front
// end and hands one at a time to the back end.
// ----------------------------------------------------------------------------
module brle_cmdq (
   input  logic               clock,
   input  logic               reset,
   input  brle_pkg::push_type push,
   output logic               room,
   input  logic               pop,
   output logic               not_empty,
   output brle_pkg::cmd_type  head
);

   localparam int PW = brle_pkg::QPTR_W;
   localparam int CW = brle_pkg::QCNT_W;

   brle_pkg::cmd_type entry_ff [brle_pkg::QDEPTH];
   logic [PW-1:0]     wp_ff, rp_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     n_push;
   logic [PW-1:0]     wp1;
   brle_pkg::cmd_type e0;

   assign e0     = push.a_valid ? push.a : push.b;
   assign n_push = CW'(push.a_valid) + CW'(push.b_valid);
   assign wp1    = wp_ff + PW'(1);

   always_ff @(posedge clock) begin
      if (n_push != '0) begin
         entry_ff[wp_ff] <= e0;
      end
      if (n_push == CW'(2)) begin
         entry_ff[wp1] <= push.b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_ff + n_push[PW-1:0];
         rp_ff    <= rp_ff + PW'(pop);
         count_ff <= count_ff + n_push - CW'(pop);
      end
   end

   assign room      = count_ff <= CW'(brle_pkg::QDEPTH - 2);
   assign not_empty = count_ff != '0;
   assign head      = entry_ff[rp_ff];

endmodule

FILE: rtl/core/brle_back.sv
// ----------------------------------------------------------------------------
// brle_back: packet writer and beat packer
// Walks each command one encoded byte per cycle unless stalled, fetching
// literal bytes from the buffer, and packs bytes into beats of up to eight.
// ----------------------------------------------------------------------------
module brle_back #(
   parameter int MAX_LITERAL = brle_pkg::MAX_LITERAL_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_not_empty,
   input  brle_pkg::cmd_type                    q_head,
   output logic                                 q_pop,
   output logic                                 rd_en,
   output logic [$clog2(MAX_LITERAL):0]         rd_addr,
   input  logic [brle_pkg::BYTE_W-1:0]          rd_data,
   output brle_pkg::rel_type                    rel,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [brle_pkg::OUT_W-1:0]           out_bytes,
   output logic [brle_pkg::BCOUNT_W-1:0]        out_count,
   output logic                                 out_row_done,
   output logic                                 out_item_last
);

   localparam int LIT_AW = $clog2(MAX_LITERAL);
   localparam int CW     = brle_pkg::CNT_W;
   localparam int BW     = brle_pkg::BYTE_W;
   localparam int LW     = brle_pkg::LANE_W;

   logic              cmd_v_ff;
   brle_pkg::cmd_type cmd_ff;
   logic [CW-1:0]     idx_ff;

   logic          s1_v_ff, s1_ram_ff, s1_last_ff, s1_row_ff;
   logic [BW-1:0] s1_imm_ff;

   logic [brle_pkg::OUT_W-1:0]    acc_ff, acc_in;
   logic [LW-1:0]                 acnt_ff;
   logic                          out_v_ff;
   logic [brle_pkg::OUT_W-1:0]    out_data_ff;
   logic [brle_pkg::BCOUNT_W-1:0] out_cnt_ff;
   logic                          out_row_ff, out_ilast_ff;

   logic          is_lit, slot_final, slot_ram;
   logic [BW-1:0] slot_imm, cur_byte;
   logic [CW-1:0] idx_m1;
   logic          pk_take, s1_go, emit;

   assign is_lit     = cmd_ff.kind == brle_pkg::CMD_LIT;
   assign slot_final = is_lit ? (idx_ff == cmd_ff.imm0 + CW'(1)) : (idx_ff == CW'(1));
   assign slot_ram   = is_lit && (idx_ff != '0);
   assign slot_imm   = (idx_ff == '0) ? cmd_ff.imm0 : cmd_ff.imm1;
   assign idx_m1     = idx_ff - CW'(1);

   assign pk_take = s1_v_ff && (!out_v_ff || out_ready);
   assign s1_go   = cmd_v_ff && (!s1_v_ff || pk_take);
   assign q_pop   = !cmd_v_ff && q_not_empty;

   // The read is only issued when the slot stage loads, so the RAM output
   // register holds the byte for as long as the slot stage stalls.
   assign rd_en     = s1_go && slot_ram;
   assign rd_addr   = {cmd_ff.bank, idx_m1[LIT_AW-1:0]};
   assign rel.valid = s1_go && slot_final && is_lit;
   assign rel.bank  = cmd_ff.bank;

   assign cur_byte = s1_ram_ff ? rd_data : s1_imm_ff;
   assign emit     = pk_take && (acnt_ff == LW'(brle_pkg::LANES - 1) || s1_last_ff);

   always_comb begin
      acc_in = acc_ff;
      for (int l = 0; l < brle_pkg::LANES; l++) begin
         if (acnt_ff == LW'(l)) begin
            acc_in[l*BW +: BW] = cur_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_head;
         idx_ff <= '0;
      end else if (s1_go) begin
         idx_ff <= idx_ff + CW'(1);
      end
      if (s1_go) begin
         s1_ram_ff  <= slot_ram;
         s1_imm_ff  <= slot_imm;
         s1_last_ff <= slot_final && cmd_ff.last;
         s1_row_ff  <= slot_final && cmd_ff.last && cmd_ff.row;
      end
      if (emit) begin
         out_data_ff  <= acc_in;
         out_cnt_ff   <= {1'b0, acnt_ff} + brle_pkg::BCOUNT_W'(1);
         out_row_ff   <= s1_row_ff;
         out_ilast_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_v_ff <= 1'b0;
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         acc_ff   <= '0;
         acnt_ff  <= '0;
      end else begin
         if (q_pop) begin
            cmd_v_ff <= 1'b1;
         end else if (s1_go && slot_final) begin
            cmd_v_ff <= 1'b0;
         end
         if (s1_go) begin
            s1_v_ff <= 1'b1;
         end else if (pk_take) begin
            s1_v_ff <= 1'b0;
         end
         if (emit) begin
            acc_ff  <= '0;
            acnt_ff <= '0;
         end else if (pk_take) begin
            acc_ff  <= acc_in;
            acnt_ff <= acnt_ff + LW'(1);
         end
         if (emit) begin
            out_v_ff <= 1'b1;
         end else if (out_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   assign out_valid     = out_v_ff;
   assign out_bytes     = out_data_ff;
   assign out_count     = out_cnt_ff;
   assign out_row_done  = out_row_ff;
   assign out_item_last = out_ilast_ff;

endmodule

FILE: rtl/core/byterun1_rle_row_packer.sv
// ----------------------------------------------------------------------------
// byterun1_rle_row_packer: byte-run RLE row packer
// Packs each row of bytes on its own into literal and run packets and
// delivers the encoded stream in beats of up to eight bytes.
// ----------------------------------------------------------------------------
// Usage
// The req channel takes one raw row byte per beat, with req_tlast on the last
// byte of a row. The rsp channel returns the encoded bytes, first byte in the
// lowest lane, with the valid byte count beside them; rsp_tuser marks the last
// beat caused by an input beat and rsp_tlast the last beat of a row.
// An input beat is taken every cycle while the command queue has room. The
// back end writes one encoded byte per cycle while not stalled, after loading
// each packet's command; the queue absorbs the difference until it fills.
// A literal flush needs the other buffer bank free, so a second flush
// stalls the input until the previous literal has been read out.
// A result beat passes the command queue, the command register, the slot
// stage and the output register; work still queued ahead delays it further.
// Reset clears all control state; the literal buffer needs no clearing. A
// stalled receiver holds the result beat and back-pressures through the
// queue to req_tready.
// ----------------------------------------------------------------------------
module byterun1_rle_row_packer #(
   parameter int MAX_LITERAL = brle_pkg::MAX_LITERAL_DEF,
   parameter int MAX_REPEAT  = brle_pkg::MAX_REPEAT_DEF,
   parameter int MIN_REPEAT  = brle_pkg::MIN_REPEAT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [brle_pkg::BYTE_W-1:0]           req_tdata,  // [7:0] byte_in
   input  logic                                  req_tlast,  // row_end
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [63:0] out_bytes, [67:64] byte_count, [71:68] zero
   output logic [brle_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast,  // row_done
   output logic                                  rsp_tuser   // item_last
);

   localparam int LIT_AW    = $clog2(MAX_LITERAL);
   localparam int RAM_DEPTH = 2 * (1 << LIT_AW);

   brle_pkg::push_type push;
   brle_pkg::rel_type  rel;
   brle_pkg::cmd_type  q_head;
   logic               q_room, q_pop, q_not_empty;

   logic                          wr_en, rd_en;
   logic [LIT_AW:0]               wr_addr, rd_addr;
   logic [brle_pkg::BYTE_W-1:0]   wr_data, rd_data;

   logic [brle_pkg::OUT_W-1:0]    out_bytes;
   logic [brle_pkg::BCOUNT_W-1:0] out_count;

   brle_front #(
      .MAX_LITERAL (MAX_LITERAL),
      .MAX_REPEAT  (MAX_REPEAT),
      .MIN_REPEAT  (MIN_REPEAT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_end   (req_tlast),
      .q_room   (q_room),
      .rel      (rel),
      .push     (push),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   brle_ram #(
      .WIDTH (brle_pkg::BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_lit_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   brle_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (q_room),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   brle_back #(
      .MAX_LITERAL (MAX_LITERAL)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rel           (rel),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_bytes     (out_bytes),
      .out_count     (out_count),
      .out_row_done  (rsp_tlast),
      .out_item_last (rsp_tuser)
   );

   assign rsp_tdata = {{(brle_pkg::RSP_TDATA_W - brle_pkg::OUT_W - brle_pkg::BCOUNT_W){1'b0}},
                       out_count, out_bytes};

`ifndef SYNTHESIS
   // The end of a row always closes the beats of the byte that ended it.
   a_row_done_is_item_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("row_done without item_last");

   // Only the closing beat of an input beat may be partly filled.
   a_inner_beat_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> out_count == brle_pkg::BCOUNT_W'(brle_pkg::LANES))
      else $error("partial beat before the last beat of an item");

   // Unused lanes must be cleared; the check covers the top lane.
   a_top_lane_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_count != brle_pkg::BCOUNT_W'(brle_pkg::LANES)
      |-> out_bytes[brle_pkg::OUT_W-1 -: brle_pkg::BYTE_W] == '0)
      else $error("lane beyond byte_count not zero");

   // A command is never pushed into a full queue.
   a_queue_safe: assert property (@(posedge clock) disable iff (reset)
      (push.a_valid || push.b_valid) |-> q_room)
      else $error("command pushed without room");
`endif

endmodule

FILE: dv/byterun1_rle_row_packer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byterun1_rle_row_packer_tb: self-checking testbench of the byte-run RLE packer
// Streams row bytes into the packer and predicts the encoded literal and run
// packets. It checks every result beat field by field against the prediction.
// Directed rows cover the edge cases, then a long receiver hold-off. Random
// rows follow, with idle bursts on both channels and pauses until the output drains.
// ----------------------------------------------------------------------------
module byterun1_rle_row_packer_tb;

   localparam int BYTE_W      = brle_pkg::BYTE_W;
   localparam int OUT_W       = brle_pkg::OUT_W;
   localparam int BCOUNT_W    = brle_pkg::BCOUNT_W;
   localparam int RSP_TDATA_W = brle_pkg::RSP_TDATA_W;
   localparam int LANES       = brle_pkg::LANES;
   localparam int MAX_LIT     = brle_pkg::MAX_LITERAL_DEF;
   localparam int MAX_REP     = brle_pkg::MAX_REPEAT_DEF;
   localparam int MIN_REP     = brle_pkg::MIN_REPEAT_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_GAP   = 16;
   localparam int END_GAP     = 40;

   typedef struct packed {
      logic [OUT_W-1:0]    out_bytes;
      logic [BCOUNT_W-1:0] byte_count;
      logic                row_done;
      logic                item_last;
   } enc_beat_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;

   // Predictor state: a private copy of the packer's row state.
   logic [7:0] lit_buf [MAX_LIT];
   int         fill_cnt   = 0;
   int         run_begin  = 0;
   bit         run_mode   = 1'b0;
   logic [7:0] prev_byte  = '0;
   bit         row_active = 1'b0;

   logic [7:0]   encoded_bytes [$];
   enc_beat_type encoded_beats_q [$];

   int  errors       = 0;
   int  cycle_count  = 0;
   int  bytes_sent   = 0;
   int  rows_sent    = 0;
   int  beats_seen   = 0;
   int  hold_left    = 0;
   int  stall_left   = 0;
   bit  idle_en      = 1'b1;

   byterun1_rle_row_packer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void emit_literal(input int n);
      if (n > MAX_LIT) n = MAX_LIT;
      if (n == 0) return;
      encoded_bytes.push_back(8'(n - 1));
      for (int i = 0; i < n; i++) encoded_bytes.push_back(lit_buf[i % MAX_LIT]);
   endfunction

   function automatic void emit_run(input int n, input logic [7:0] value);
      encoded_bytes.push_back(8'(256 - (n - 1)));
      encoded_bytes.push_back(value);
   endfunction

   // Advances the row state by one byte and queues the result beats it causes.
   function automatic void pack_row_byte(input logic [7:0] c, input logic row_end);
      enc_beat_type beat;
      int           nbeats;
      int           idx;
      encoded_bytes.delete();
      if (!row_active) begin
         lit_buf[0] = c;
         fill_cnt   = 1;
         run_begin  = 0;
         run_mode   = 1'b0;
         prev_byte  = c;
         row_active = 1'b1;
      end else begin
         if (!run_mode) begin
            if (fill_cnt >= MAX_LIT) begin
               // A full buffer is flushed and the new byte opens the next one.
               emit_literal(fill_cnt);
               lit_buf[0] = c;
               fill_cnt   = 1;
               run_begin  = 0;
            end else begin
               lit_buf[fill_cnt % MAX_LIT] = c;
               fill_cnt++;
               if (c == prev_byte) begin
                  if (fill_cnt - run_begin >= MIN_REP) begin
                     if (run_begin > 0) emit_literal(run_begin);
                     run_mode = 1'b1;
                  end else if (run_begin == 0) begin
                     // Two equal bytes at the head of the buffer already form a run.
                     run_mode = 1'b1;
                  end
               end else begin
                  run_begin = fill_cnt - 1;
               end
            end
         end else begin
            fill_cnt++;
            if (c != prev_byte || fill_cnt - run_begin > MAX_REP) begin
               emit_run(fill_cnt - 1 - run_begin, prev_byte);
               lit_buf[0] = c;
               fill_cnt   = 1;
               run_begin  = 0;
               run_mode   = 1'b0;
            end
         end
         fill_cnt  = fill_cnt & 8'hFF;
         prev_byte = c;
      end
      if (row_end) begin
         if (!run_mode) emit_literal(fill_cnt);
         else emit_run(fill_cnt - run_begin, prev_byte);
         row_active = 1'b0;
         run_mode   = 1'b0;
         fill_cnt   = 0;
         run_begin  = 0;
      end
      nbeats = (encoded_bytes.size() + LANES - 1) / LANES;
      for (int k = 0; k < nbeats; k++) begin
         beat = '0;
         for (int j = 0; j < LANES; j++) begin
            idx = k * LANES + j;
            if (idx < encoded_bytes.size()) begin
               beat.out_bytes[8*j +: 8] = encoded_bytes[idx];
               beat.byte_count++;
            end
         end
         beat.row_done  = row_end && (k == nbeats - 1);
         beat.item_last = (k == nbeats - 1);
         encoded_beats_q.push_back(beat);
      end
   endfunction

   // Result side: checks each accepted beat and decides the next tready.
   always @(posedge clock) begin
      enc_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen++;
         if (encoded_beats_q.size() == 0) begin
            $error("unexpected result beat: tdata=%h tlast=%b tuser=%b",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            want = encoded_beats_q.pop_front();
            if (rsp_tdata[OUT_W-1:0] !== want.out_bytes) begin
               $error("out_bytes: expected %h, actual %h", want.out_bytes,
                      rsp_tdata[OUT_W-1:0]);
               errors++;
            end
            if (rsp_tdata[OUT_W +: BCOUNT_W] !== want.byte_count) begin
               $error("byte_count: expected %0d, actual %0d", want.byte_count,
                      rsp_tdata[OUT_W +: BCOUNT_W]);
               errors++;
            end
            if (rsp_tdata[RSP_TDATA_W-1:OUT_W+BCOUNT_W] !== '0) begin
               $error("tdata padding: expected 0, actual %h",
                      rsp_tdata[RSP_TDATA_W-1:OUT_W+BCOUNT_W]);
               errors++;
            end
            if (rsp_tlast !== want.row_done) begin
               $error("row_done: expected %b, actual %b", want.row_done, rsp_tlast);
               errors++;
            end
            if (rsp_tuser !== want.item_last) begin
               $error("item_last: expected %b, actual %b", want.item_last, rsp_tuser);
               errors++;
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic row_end);
      int gap;
      if (idle_en && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= row_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pack_row_byte(value, row_end);
      bytes_sent++;
      if (row_end) rows_sent++;
   endtask

   task automatic send_row(input logic [7:0] row [$]);
      foreach (row[i]) send_byte(row[i], i == row.size() - 1);
   endtask

   // The sender stops and waits until every predicted beat has arrived.
   task automatic wait_drained(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (encoded_beats_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic test_directed();
      send_row('{8'h00});
      send_row('{8'hFF});
      send_row('{8'hA5, 8'hA5});
      send_row('{8'h5A, 8'h5A, 8'h5A});
      send_row('{8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h04});
      send_row('{8'h10, 8'h20, 8'h20});
      send_row('{8'h77, 8'h77, 8'h12});
      send_row('{8'h80, 8'h7F, 8'h80, 8'h7F});
      wait_drained(PHASE_GAP);
   endtask

   // A row without repeats overflows the literal buffer and ends on the
   // overflowing byte itself.
   task automatic test_literal_overflow();
      logic [7:0] row [$];
      for (int i = 0; i < MAX_LIT + 1; i++) row.push_back(8'(i * 53 + 200));
      send_row(row);
      wait_drained(PHASE_GAP);
   endtask

   // A run beyond the longest repeat count after a single literal byte, sent
   // without idling.
   task automatic test_longest_runs();
      logic [7:0] row [$];
      idle_en = 1'b0;
      row.push_back(8'h3C);
      for (int i = 0; i < MAX_REP + 1; i++) row.push_back(8'h96);
      row.push_back(8'h69);
      send_row(row);
      wait_drained(PHASE_GAP);
      @(negedge clock) idle_en = 1'b1;
      @(posedge clock);
   endtask

   // The receiver holds off while literal rows keep coming, so the packer
   // fills up and stalls its input.
   task automatic test_backpressure();
      @(negedge clock) hold_left = 400;
      @(posedge clock);
      for (int i = 0; i < 60; i++) send_byte(8'($urandom_range(0, 255)), i % 20 == 19);
      wait_drained(PHASE_GAP);
   endtask

   task automatic test_random_rows(input int n_items);
      logic [7:0] row [$];
      logic [7:0] value;
      int         row_len;
      int         seg_len;
      int         start;
      int         left;
      start = bytes_sent;
      while (bytes_sent - start < n_items) begin
         left = n_items - (bytes_sent - start);
         if ($urandom_range(0, 4) == 0) begin
            // Noise: bytes from a small or full alphabet with random row ends.
            seg_len = $urandom_range(1, 20);
            if (seg_len > left) seg_len = left;
            for (int i = 0; i < seg_len; i++) begin
               value = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom_range(0, 255));
               send_byte(value, $urandom_range(0, 5) == 0);
            end
         end else begin
            row.delete();
            row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
            if (row_len > left) row_len = left;
            while (row.size() < row_len) begin
               if ($urandom_range(0, 1) == 0) begin
                  seg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140)
                                                        : $urandom_range(2, 6);
                  value = 8'($urandom_range(0, 255));
                  for (int i = 0; i < seg_len; i++) row.push_back(value);
               end else begin
                  seg_len = $urandom_range(1, 8);
                  for (int i = 0; i < seg_len; i++)
                     row.push_back(8'($urandom_range(0, 255)));
               end
            end
            while (row.size() > row_len) void'(row.pop_back());
            send_row(row);
         end
         if ($urandom_range(0, 15) == 0) wait_drained(PHASE_GAP);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_literal_overflow();
      test_longest_runs();
      test_backpressure();
      test_random_rows(60);
      req_tvalid <= 1'b0;
      @(negedge clock) idle_en = 1'b0;
      @(posedge clock);
      test_random_rows(30);
      wait_drained(END_GAP);
      $display("Sent %0d row bytes in %0d rows and checked %0d encoded beats.",
               bytes_sent, rows_sent, beats_seen);
      $display("Covered short rows, a literal overflow, a run past the longest repeat,");
      $display("a long receiver hold-off and random rows with and without idling.");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: byterun1_rle_row_packer.f
rtl/core/brle_pkg.sv
rtl/core/brle_ram.sv
rtl/core/brle_front.sv
rtl/core/brle_cmdq.sv
rtl/core/brle_back.sv
rtl/core/byterun1_rle_row_packer.sv
dv/byterun1_rle_row_packer_tb.sv
